[rtl/lbl_pkg.sv]
// Shared types, character codes and token kinds for the bracket language lexer.
package lbl_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int QDEPTH        = 3;
    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    localparam logic [7:0] CH_LB    = 8'h5B;
    localparam logic [7:0] CH_RB    = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    typedef enum logic [2:0] {
        K_LB     = 3'd0,
        K_RB     = 3'd1,
        K_WS     = 3'd2,
        K_STR    = 3'd3,
        K_NUM    = 3'd4,
        K_SYM    = 3'd5,
        K_SEMI   = 3'd6,
        K_UNTERM = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_tok;

    typedef struct packed {
        logic two;
        logic last;
        t_tok r0;
        t_tok r1;
    } t_entry;

    function automatic t_kind f_classify(input logic [7:0] c);
        t_kind k;
        case (c) inside
            CH_LB:                  k = K_LB;
            CH_RB:                  k = K_RB;
            CH_SPACE, CH_NL, CH_TAB: k = K_WS;
            CH_QUOTE:               k = K_STR;
            CH_SEMI:                k = K_SEMI;
            [CH_D0:CH_D9]:          k = K_NUM;
            default:                k = K_SYM;
        endcase
        return k;
    endfunction

endpackage

[rtl/lbl_if.sv]
// Valid/ready channel interfaces for characters in and tokens out.
interface lbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface lbl_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        final_token;
    logic        end_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output final_token, output end_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input final_token, input end_of_run,
                    output ready);
endinterface

[rtl/lbl_front.sv]
// Front end: accepts characters, tracks the open token and forms result entries.
module lbl_front #(
    parameter int POS_WIDTH = lbl_pkg::POS_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lbl_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output lbl_pkg::t_entry o_entry
);
    import lbl_pkg::*;

    localparam int LW = (POS_WIDTH + 1 > 17) ? POS_WIDTH + 1 : 17;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    t_kind                r_kind, n_kind;
    logic                 r_open, n_open;
    logic [POS_WIDTH-1:0] r_start, n_start;
    logic [POS_WIDTH-1:0] r_pos, n_pos;

    function automatic logic [15:0] f_len(input logic [LW-1:0] s, input logic [LW-1:0] e);
        logic [LW-1:0] d;
        d = (e > s) ? e - s : LW'(1);
        return (d > LW'(FIELD_MAX)) ? FIELD_MAX : d[15:0];
    endfunction

    function automatic logic [15:0] f_sat(input logic [LW-1:0] s);
        return (s > LW'(FIELD_MAX)) ? FIELD_MAX : s[15:0];
    endfunction

    logic accept;
    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [LW-1:0] p, p1, os;
        t_kind cls, fk;
        logic cons, str_close, has_a, has_b, has_c, open_after;
        t_tok ta, tb, tc;
        logic [POS_WIDTH-1:0] start_after;
        t_kind kind_after;

        p   = LW'(r_pos);
        p1  = LW'(r_pos) + LW'(1);
        os  = LW'(r_start);
        cls = f_classify(i_in.ch);

        cons      = 1'b0;
        str_close = 1'b0;
        if (r_open) begin
            case (r_kind)
                K_WS:    cons = (i_in.ch == CH_SPACE);
                K_STR: begin
                    cons      = 1'b1;
                    str_close = (i_in.ch == CH_QUOTE);
                end
                K_NUM:   cons = (i_in.ch inside {[CH_D0:CH_D9]}) || (i_in.ch == CH_DOT);
                default: cons = !(i_in.ch inside {CH_SPACE, CH_LB, CH_RB, CH_SEMI});
            endcase
        end

        has_a = str_close || (r_open && !cons);
        ta.kind  = str_close ? K_STR : r_kind;
        ta.start = f_sat(os);
        ta.len   = str_close ? f_len(os, p1) : f_len(os, p);

        has_b    = !cons && (cls inside {K_LB, K_RB, K_SEMI});
        tb.kind  = cls;
        tb.start = f_sat(p);
        tb.len   = f_len(p, p1);

        if (r_open && cons && !str_close) begin
            open_after  = 1'b1;
            kind_after  = r_kind;
            start_after = r_start;
        end else if (!cons && !has_b) begin
            open_after  = 1'b1;
            kind_after  = cls;
            start_after = r_pos;
        end else begin
            open_after  = 1'b0;
            kind_after  = cons ? r_kind : cls;
            start_after = cons ? r_start : r_pos;
        end

        has_c    = i_in.last && open_after;
        fk       = (kind_after == K_STR) ? K_UNTERM : kind_after;
        tc.kind  = fk;
        tc.start = f_sat(LW'(start_after));
        tc.len   = f_len(LW'(start_after), p1);

        o_entry.last = i_in.last;
        if (has_a) begin
            o_entry.r0  = ta;
            o_entry.r1  = has_b ? tb : tc;
            o_entry.two = has_b || has_c;
        end else begin
            o_entry.r0  = has_b ? tb : tc;
            o_entry.r1  = tc;
            o_entry.two = 1'b0;
        end
        o_push = accept && (has_a || has_b || has_c);

        n_kind = r_kind;
        n_open = r_open;
        n_start = r_start;
        n_pos = r_pos;
        if (accept) begin
            n_kind = kind_after;
            if (i_in.last) begin
                n_open  = 1'b0;
                n_start = '0;
                n_pos   = '0;
            end else begin
                n_open  = open_after;
                n_start = start_after;
                n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + POS_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= K_LB;
            r_open  <= 1'b0;
            r_start <= '0;
            r_pos   <= '0;
        end else begin
            r_kind  <= n_kind;
            r_open  <= n_open;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last) |=> (r_pos == '0 && !r_open))
        else $error("position or open flag not cleared after last character");
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last) |-> o_push)
        else $error("last character produced no token");
`endif
endmodule

[rtl/lbl_queue.sv]
// Short entry queue between the front end and the token output stage.
module lbl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbl_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output lbl_pkg::t_entry o_head,
    output logic            o_empty
);
    import lbl_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_entry          r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [AW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] v);
        return (v == AW'(QDEPTH - 1)) ? '0 : v + AW'(1);
    endfunction

    always_comb begin
        n_wp  = i_push ? f_inc(r_wp) : r_wp;
        n_rp  = i_pop  ? f_inc(r_rp) : r_rp;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif
endmodule

[rtl/lbl_back.sv]
// Back end: unpacks queued entries into one token transfer per cycle while the output is ready.
module lbl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbl_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    lbl_tok_if.source       o_tok
);
    import lbl_pkg::*;

    logic r_sub, n_sub;
    logic xfer, tail;
    t_tok tok;

    assign tail = !i_head.two || r_sub;
    assign tok  = r_sub ? i_head.r1 : i_head.r0;
    assign xfer = o_tok.valid && o_tok.ready;

    assign o_tok.valid        = !i_empty;
    assign o_tok.token_kind   = tok.kind;
    assign o_tok.token_start  = tok.start;
    assign o_tok.token_length = tok.len;
    assign o_tok.end_of_run   = tail;
    assign o_tok.final_token  = tail && i_head.last;
    assign o_pop              = xfer && tail;

    always_comb begin
        n_sub = r_sub;
        if (xfer) begin
            n_sub = !tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

`ifndef ASSERT_OFF
    a_sub_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_empty && i_head.two))
        else $error("second token selected without a two-token entry");
`endif
endmodule

[rtl/bracket_language_lexer.sv]
// Top level of the bracket language lexer.
// Lexes one character byte per clock: a character is accepted every cycle
// while the three-entry token queue has room, and each character yields zero,
// one or two tokens. Tokens leave one per cycle while the receiver is ready,
// so a character that closes one token and emits another (or flushes at
// end of string) occupies the output port for both tokens; the queue absorbs
// that while the next characters keep coming. Tokens are registered in the queue.
// Positions count in POS_WIDTH bits, saturate at their maximum and are
// reported clamped to 16 bits; they return to zero after each last character.
module bracket_language_lexer #(
    parameter int POS_WIDTH = lbl_pkg::POS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbl_in_if.sink    i_in,
    lbl_tok_if.source o_tok
);
    import lbl_pkg::*;

    logic   push, full, pop, empty;
    t_entry entry, head;

    lbl_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    lbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    lbl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );
endmodule
